[src/lpcd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpcd_pkg
// Shared types and constants of the LED panel command decoder.
// ----------------------------------------------------------------------------
package lpcd_pkg;

	// command codes in the high nibble of a command byte
	localparam logic [3:0] CMD_STATUS    = 4'd1;
	localparam logic [3:0] CMD_PANEL     = 4'd2;
	localparam logic [3:0] CMD_ROW       = 4'd3;
	localparam logic [3:0] CMD_CHUNK     = 4'd4;
	localparam logic [3:0] CMD_NIB_FIRST = 4'd5;
	localparam logic [3:0] CMD_NIB_LAST  = 4'd12;
	localparam logic [3:0] CMD_WRITE     = 4'd13;

	// four panels, one status reply each
	localparam int NUM_PANELS = 4;
	localparam int BEAT_W     = $clog2(NUM_PANELS);

	// result kinds, coded as on the kind port
	typedef enum logic [1:0] {
		KIND_WRITE   = 2'd0,
		KIND_STATUS  = 2'd1,
		KIND_ILLEGAL = 2'd2
	} kind_t;

	// one queued job from front to back
	typedef struct packed {
		kind_t       kind;
		logic [1:0]  panel;
		logic [3:0]  row;
		logic [3:0]  chunk;
		logic [31:0] data;
	} job_t;

endpackage

[src/lpcd_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpcd_front
// Accepts command bytes, updates the address and data latches and queues
// one job for each byte that produces results.
// ----------------------------------------------------------------------------
module lpcd_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         cmd_byte,
	input  logic               q_full,
	output logic               push,
	output lpcd_pkg::job_t     push_job
);

	logic [1:0]  panel_q;
	logic [3:0]  row_q;
	logic [3:0]  chunk_q;
	logic [31:0] word_q;
	logic [3:0]  cmd;
	logic [3:0]  opd;
	logic [2:0]  nib_idx;
	logic        accept;

	assign cmd      = cmd_byte[7:4];
	assign opd      = cmd_byte[3:0];
	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign nib_idx  = 3'(cmd - lpcd_pkg::CMD_NIB_FIRST);

	// latches, all cleared by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			panel_q <= '0;
			row_q   <= '0;
			chunk_q <= '0;
			word_q  <= '0;
		end else if (accept) begin
			if (cmd == lpcd_pkg::CMD_PANEL) begin
				panel_q <= opd[1:0];
			end
			if (cmd == lpcd_pkg::CMD_ROW) begin
				row_q <= opd;
			end
			if (cmd == lpcd_pkg::CMD_CHUNK) begin
				chunk_q <= opd;
			end
			if (cmd >= lpcd_pkg::CMD_NIB_FIRST && cmd <= lpcd_pkg::CMD_NIB_LAST) begin
				word_q[{nib_idx, 2'b00} +: 4] <= opd;
			end
		end
	end

	// classify the item into a job for the back end
	always_comb begin
		push_job = '0;
		push     = 1'b0;
		case (cmd)
			lpcd_pkg::CMD_STATUS: begin
				push          = accept;
				push_job.kind = lpcd_pkg::KIND_STATUS;
			end
			lpcd_pkg::CMD_WRITE: begin
				push           = accept;
				push_job.kind  = lpcd_pkg::KIND_WRITE;
				push_job.panel = panel_q;
				push_job.row   = row_q;
				push_job.chunk = chunk_q;
				push_job.data  = word_q;
			end
			lpcd_pkg::CMD_PANEL, lpcd_pkg::CMD_ROW, lpcd_pkg::CMD_CHUNK: begin
				push = 1'b0;
			end
			default: begin
				// nibble loads produce nothing, remaining codes are illegal
				if (cmd < lpcd_pkg::CMD_NIB_FIRST || cmd > lpcd_pkg::CMD_NIB_LAST) begin
					push          = accept;
					push_job.kind = lpcd_pkg::KIND_ILLEGAL;
				end
			end
		endcase
	end

endmodule

[src/lpcd_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpcd_queue
// Small job queue between front and back end.
// ----------------------------------------------------------------------------
module lpcd_queue #(
	parameter int DEPTH = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  lpcd_pkg::job_t push_job,
	output logic           full,
	input  logic           pop,
	output logic           not_empty,
	output lpcd_pkg::job_t head_job
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	lpcd_pkg::job_t   slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign head_job  = slot_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

[src/lpcd_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpcd_back
// Carries out queued jobs: one result per write or illegal job, four status
// replies per status job, through a registered output stage.
// ----------------------------------------------------------------------------
module lpcd_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [15:0]    switches,
	input  logic           q_valid,
	input  lpcd_pkg::job_t head_job,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_stall,
	output logic [1:0]     kind,
	output logic [7:0]     status_byte,
	output logic [1:0]     wr_panel,
	output logic [3:0]     wr_row,
	output logic [3:0]     wr_chunk,
	output logic [31:0]    wr_data,
	output logic           last
);

	logic [lpcd_pkg::BEAT_W-1:0] beat_q;
	logic                        out_valid_q;
	logic [1:0]                  kind_q;
	logic [7:0]                  status_q;
	logic [1:0]                  panel_q;
	logic [3:0]                  row_q;
	logic [3:0]                  chunk_q;
	logic [31:0]                 data_q;
	logic                        last_q;
	logic                        load;
	logic                        is_status;
	logic                        final_beat;
	logic [3:0]                  sw_nib;
	logic [3:0]                  beat_num;

	assign load       = q_valid && (!out_valid_q || !out_stall);
	assign is_status  = (head_job.kind == lpcd_pkg::KIND_STATUS);
	assign final_beat = !is_status ||
		(beat_q == lpcd_pkg::BEAT_W'(lpcd_pkg::NUM_PANELS - 1));
	assign pop        = load && final_beat;
	assign sw_nib     = switches[{beat_q, 2'b00} +: 4];
	assign beat_num   = 4'(beat_q) + 4'd1;

	// status beat counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				beat_q <= final_beat ? '0 : beat_q + lpcd_pkg::BEAT_W'(1);
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (load) begin
			kind_q   <= head_job.kind;
			status_q <= is_status ? {beat_num, sw_nib} : 8'h00;
			panel_q  <= head_job.panel;
			row_q    <= head_job.row;
			chunk_q  <= head_job.chunk;
			data_q   <= head_job.data;
			last_q   <= final_beat;
		end
	end

	assign out_valid   = out_valid_q;
	assign kind        = kind_q;
	assign status_byte = status_q;
	assign wr_panel    = panel_q;
	assign wr_row      = row_q;
	assign wr_chunk    = chunk_q;
	assign wr_data     = data_q;
	assign last        = last_q;

endmodule

[src/led_panel_command_decoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_panel_command_decoder
// Board-side decoder for LED panel command bytes: address and data latches,
// frame-memory write results, status replies and illegal-command results.
// ----------------------------------------------------------------------------
//  channel  signals                                      handshake
//  in       in_valid, in_stall, cmd_byte                 valid && !stall
//  out      out_valid, out_stall, kind, status_byte,     valid && !stall
//           wr_panel, wr_row, wr_chunk, wr_data, last
//  cfg      cfg_valid, cfg_ready, cfg_data               valid && ready
//
//  one command byte is taken per cycle while the job queue has room
//  a write or illegal result passes through the job queue, then the output register
//  a status request holds the output stage for four replies, one per panel
//  in_stall rises only when the queue is full; out_stall holds the output
//  register and backs up the queue
//  arst_n clears the latches, the switch register, the queue and out_valid
// ----------------------------------------------------------------------------
module led_panel_command_decoder #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  cmd_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [7:0]  status_byte,
	output logic [1:0]  wr_panel,
	output logic [3:0]  wr_row,
	output logic [3:0]  wr_chunk,
	output logic [31:0] wr_data,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	logic [15:0]    switches_q;
	logic           push;
	lpcd_pkg::job_t push_job;
	logic           q_full;
	logic           pop;
	logic           q_valid;
	lpcd_pkg::job_t head_job;

	// panel switch register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			switches_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			switches_q <= cfg_data;
		end
	end

	// front end: accept and classify
	lpcd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cmd_byte (cmd_byte),
		.q_full   (q_full),
		.push     (push),
		.push_job (push_job)
	);

	// job queue
	lpcd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_job  (push_job),
		.full      (q_full),
		.pop       (pop),
		.not_empty (q_valid),
		.head_job  (head_job)
	);

	// back end: produce results
	lpcd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.switches    (switches_q),
		.q_valid     (q_valid),
		.head_job    (head_job),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.kind        (kind),
		.status_byte (status_byte),
		.wr_panel    (wr_panel),
		.wr_row      (wr_row),
		.wr_chunk    (wr_chunk),
		.wr_data     (wr_data),
		.last        (last)
	);

endmodule

[sim/led_panel_command_decoder_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_panel_command_decoder_test
// Self-checking bench for the LED panel command decoder. Command bytes go in
// through a directed table and then through random address/nibble/write
// sequences, status requests and noise. Every accepted byte is decoded by a
// local predictor of the latches and switch setting, and each result item
// is checked against the oldest expected reply. Both sides idle at random.
// ----------------------------------------------------------------------------
module led_panel_command_decoder_test;

	// commands that the block rejects
	localparam logic [3:0] CMD_BAD_ZERO = 4'd0;
	localparam logic [3:0] CMD_BAD_E    = 4'd14;
	localparam logic [3:0] CMD_BAD_F    = 4'd15;

	localparam int LONG_HOLD    = 60;
	localparam int SETTLE_DELAY = 8;

	// one result item as seen on the output ports
	typedef struct packed {
		lpcd_pkg::kind_t kind;
		logic [7:0]      status;
		logic [1:0]      panel;
		logic [3:0]      row;
		logic [3:0]      chunk;
		logic [31:0]     data;
		logic            last;
	} reply_t;

	// one row of the directed table
	typedef struct packed {
		logic [7:0] b;
		logic       typed;
		reply_t     r;
	} step_t;

	localparam reply_t NO_REPLY      =
		'{lpcd_pkg::KIND_WRITE, 8'h00, 2'd0, 4'd0, 4'd0, 32'd0, 1'b0};
	localparam reply_t ZERO_WRITE    =
		'{lpcd_pkg::KIND_WRITE, 8'h00, 2'd0, 4'd0, 4'd0, 32'd0, 1'b1};
	localparam reply_t ILLEGAL_REPLY =
		'{lpcd_pkg::KIND_ILLEGAL, 8'h00, 2'd0, 4'd0, 4'd0, 32'd0, 1'b1};

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  cmd_byte;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  kind;
	logic [7:0]  status_byte;
	logic [1:0]  wr_panel;
	logic [3:0]  wr_row;
	logic [3:0]  wr_chunk;
	logic [31:0] wr_data;
	logic        last;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [15:0] cfg_data;

	// predictor state
	logic [15:0] switch_setting;
	logic [1:0]  exp_panel;
	logic [3:0]  exp_row;
	logic [3:0]  exp_chunk;
	logic [31:0] chunk_word;

	reply_t      pending_replies [$];
	step_t       dir_steps [25];
	int          fault_count;
	int          bytes_sent;
	bit          no_gaps;
	bit          long_hold_req;

	led_panel_command_decoder uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.cmd_byte    (cmd_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.kind        (kind),
		.status_byte (status_byte),
		.wr_panel    (wr_panel),
		.wr_row      (wr_row),
		.wr_chunk    (wr_chunk),
		.wr_data     (wr_data),
		.last        (last),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// decode one accepted byte: update the latches, queue the replies it causes
	function automatic void decode_byte(input logic [7:0] b, input bit enqueue);
		logic [3:0] op;
		logic [3:0] opd;
		reply_t     r;
		op  = b[7:4];
		opd = b[3:0];
		r   = NO_REPLY;
		if (op == lpcd_pkg::CMD_STATUS) begin
			for (int k = 0; k < lpcd_pkg::NUM_PANELS; k++) begin
				r        = NO_REPLY;
				r.kind   = lpcd_pkg::KIND_STATUS;
				r.status = {4'(k + 1), switch_setting[4*k +: 4]};
				r.last   = (k == lpcd_pkg::NUM_PANELS - 1);
				if (enqueue)
					pending_replies.push_back(r);
			end
		end else if (op == lpcd_pkg::CMD_PANEL) begin
			exp_panel = opd[1:0];
		end else if (op == lpcd_pkg::CMD_ROW) begin
			exp_row = opd;
		end else if (op == lpcd_pkg::CMD_CHUNK) begin
			exp_chunk = opd;
		end else if (op >= lpcd_pkg::CMD_NIB_FIRST && op <= lpcd_pkg::CMD_NIB_LAST) begin
			chunk_word[4*(op - lpcd_pkg::CMD_NIB_FIRST) +: 4] = opd;
		end else if (op == lpcd_pkg::CMD_WRITE) begin
			r.kind  = lpcd_pkg::KIND_WRITE;
			r.panel = exp_panel;
			r.row   = exp_row;
			r.chunk = exp_chunk;
			r.data  = chunk_word;
			r.last  = 1'b1;
			if (enqueue)
				pending_replies.push_back(r);
		end else begin
			if (enqueue)
				pending_replies.push_back(ILLEGAL_REPLY);
		end
	endfunction

	// offer one byte after a random gap and wait until it is taken
	task automatic offer_byte(input logic [7:0] b, input bit typed, input reply_t r);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd_byte <= b;
		do
			@(posedge clk);
		while (in_stall);
		if (typed) begin
			decode_byte(b, 1'b0);
			pending_replies.push_back(r);
		end else begin
			decode_byte(b, 1'b1);
		end
		bytes_sent++;
	endtask

	// wait for every expected reply, then let the block drain
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_replies.size() != 0)
			@(posedge clk);
		repeat (SETTLE_DELAY) @(posedge clk);
	endtask

	// write the switch register while the block is idle
	task automatic write_switches(input logic [15:0] v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid      <= 1'b0;
		switch_setting = v;
	endtask

	// random traffic: mostly address/nibble runs closed by a write
	task automatic random_bytes(input int count);
		int target;
		int pick;
		int runs;
		target = bytes_sent + count;
		while (bytes_sent < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 60) begin
				runs = $urandom_range(0, 10);
				repeat (runs)
					offer_byte({4'($urandom_range(lpcd_pkg::CMD_PANEL,
						lpcd_pkg::CMD_NIB_LAST)), 4'($urandom_range(0, 15))},
						1'b0, NO_REPLY);
				offer_byte({lpcd_pkg::CMD_WRITE, 4'($urandom_range(0, 15))},
					1'b0, NO_REPLY);
			end else if (pick < 75) begin
				offer_byte({lpcd_pkg::CMD_STATUS, 4'($urandom_range(0, 15))},
					1'b0, NO_REPLY);
			end else begin
				offer_byte(8'($urandom_range(0, 255)), 1'b0, NO_REPLY);
			end
		end
	endtask

	// receiver: random hold-off before each item, one long hold on request
	initial begin
		int n;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (long_hold_req) begin
				n             = LONG_HOLD;
				long_hold_req = 1'b0;
			end else begin
				n = no_gaps ? 0 : $urandom_range(0, 6);
			end
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
				out_stall <= 1'b0;
			end
			do
				@(posedge clk);
			while (!out_valid);
		end
	end

	// result checker
	always @(posedge clk) begin
		reply_t got;
		reply_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{lpcd_pkg::kind_t'(kind), status_byte, wr_panel, wr_row, wr_chunk,
				wr_data, last};
			if (pending_replies.size() == 0) begin
				fault_count++;
				if (fault_count <= 10)
					$display("%0t: unexpected result kind %0d status %h data %h",
						$realtime, got.kind, got.status, got.data);
			end else begin
				want = pending_replies.pop_front();
				if (got !== want) begin
					fault_count++;
					if (fault_count <= 10) begin
						$display("%0t: expected kind %0d status %h addr %0d/%0d/%0d data %h last %0d",
							$realtime, want.kind, want.status, want.panel, want.row,
							want.chunk, want.data, want.last);
						$display("%0t: got      kind %0d status %h addr %0d/%0d/%0d data %h last %0d",
							$realtime, got.kind, got.status, got.panel, got.row,
							got.chunk, got.data, got.last);
					end
				end
			end
		end
	end

	// watchdog
	initial begin
		#1_000_000;
		$display("FAIL led_panel_command_decoder");
		$finish;
	end

	// main sequence
	initial begin
		clk            = 1'b0;
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		cmd_byte       = 8'h00;
		out_stall      = 1'b0;
		cfg_valid      = 1'b0;
		cfg_data       = 16'h0000;
		switch_setting = 16'h0000;
		exp_panel      = 2'd0;
		exp_row        = 4'd0;
		exp_chunk      = 4'd0;
		chunk_word     = 32'd0;
		fault_count    = 0;
		bytes_sent     = 0;
		no_gaps        = 1'b0;
		long_hold_req  = 1'b0;

		// directed table: extremes, every command, rejected codes
		dir_steps = '{
			'{{lpcd_pkg::CMD_WRITE, 4'h0},              1'b1, ZERO_WRITE},
			'{{CMD_BAD_ZERO, 4'h0},                     1'b1, ILLEGAL_REPLY},
			'{{lpcd_pkg::CMD_STATUS, 4'hF},             1'b0, NO_REPLY},
			'{{lpcd_pkg::CMD_PANEL, 4'hF},              1'b0, NO_REPLY},
			'{{lpcd_pkg::CMD_ROW, 4'hF},                1'b0, NO_REPLY},
			'{{lpcd_pkg::CMD_CHUNK, 4'hC},              1'b0, NO_REPLY},
			'{{lpcd_pkg::CMD_NIB_FIRST, 4'hF},          1'b0, NO_REPLY},
			'{{lpcd_pkg::CMD_NIB_FIRST + 4'd1, 4'hF},   1'b0, NO_REPLY},
			'{{lpcd_pkg::CMD_NIB_FIRST + 4'd2, 4'hF},   1'b0, NO_REPLY},
			'{{lpcd_pkg::CMD_NIB_FIRST + 4'd3, 4'hF},   1'b0, NO_REPLY},
			'{{lpcd_pkg::CMD_NIB_FIRST + 4'd4, 4'hF},   1'b0, NO_REPLY},
			'{{lpcd_pkg::CMD_NIB_FIRST + 4'd5, 4'hF},   1'b0, NO_REPLY},
			'{{lpcd_pkg::CMD_NIB_FIRST + 4'd6, 4'hF},   1'b0, NO_REPLY},
			'{{lpcd_pkg::CMD_NIB_LAST, 4'hF},           1'b0, NO_REPLY},
			'{{lpcd_pkg::CMD_WRITE, 4'h7},              1'b0, NO_REPLY},
			'{{CMD_BAD_E, 4'h5},                        1'b1, ILLEGAL_REPLY},
			'{{CMD_BAD_F, 4'hF},                        1'b1, ILLEGAL_REPLY},
			'{{lpcd_pkg::CMD_PANEL, 4'h0},              1'b0, NO_REPLY},
			'{{lpcd_pkg::CMD_ROW, 4'h0},                1'b0, NO_REPLY},
			'{{lpcd_pkg::CMD_CHUNK, 4'hF},              1'b0, NO_REPLY},
			'{{lpcd_pkg::CMD_NIB_FIRST, 4'h0},          1'b0, NO_REPLY},
			'{{lpcd_pkg::CMD_NIB_LAST, 4'h0},           1'b0, NO_REPLY},
			'{{lpcd_pkg::CMD_WRITE, 4'hF},              1'b0, NO_REPLY},
			'{{lpcd_pkg::CMD_STATUS, 4'h0},             1'b0, NO_REPLY},
			'{{lpcd_pkg::CMD_WRITE, 4'h0},              1'b0, NO_REPLY}
		};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_steps[i])
			offer_byte(dir_steps[i].b, dir_steps[i].typed, dir_steps[i].r);

		// all switches high
		settle();
		write_switches(16'hFFFF);
		random_bytes(100);

		// switches low; long receiver hold fills the queue and stalls input
		settle();
		write_switches(16'h0000);
		long_hold_req = 1'b1;
		no_gaps       = 1'b1;
		repeat (12) begin
			offer_byte({lpcd_pkg::CMD_WRITE, 4'($urandom_range(0, 15))}, 1'b0, NO_REPLY);
			offer_byte({CMD_BAD_F, 4'($urandom_range(0, 15))}, 1'b0, NO_REPLY);
		end
		no_gaps = 1'b0;
		random_bytes(100);

		// back-to-back stretch with no idling on either side
		settle();
		write_switches(16'($urandom_range(0, 65535)));
		no_gaps = 1'b1;
		random_bytes(100);
		no_gaps = 1'b0;

		// sender pauses mid-phase until all replies are in
		settle();
		write_switches(16'($urandom_range(0, 65535)));
		random_bytes(50);
		settle();
		random_bytes(50);

		settle();
		write_switches(16'($urandom_range(0, 65535)));
		random_bytes(100);

		// drain, then let any late item show up
		in_valid <= 1'b0;
		for (int i = 0; i < 5000 && pending_replies.size() != 0; i++)
			@(posedge clk);
		repeat (20) @(posedge clk);
		fault_count += pending_replies.size();

		if (fault_count == 0)
			$display("PASS led_panel_command_decoder");
		else
			$display("FAIL led_panel_command_decoder");
		$finish;
	end

endmodule

[files.f]
src/lpcd_pkg.sv
src/lpcd_front.sv
src/lpcd_queue.sv
src/lpcd_back.sv
src/led_panel_command_decoder.sv
sim/led_panel_command_decoder_test.sv
